// File: rtl/kst_pkg.sv
package kst_pkg;

  localparam int KEY_W   = 25;
  localparam int CMD_W   = 3;
  localparam int PHASE_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_PRESS   = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_INVALID      = 3'd0,
    PH_REGISTERED   = 3'd1,
    PH_TRIGGERED    = 3'd2,
    PH_PRESSED      = 3'd3,
    PH_UNREGISTERED = 3'd4,
    PH_RELEASED     = 3'd5
  } phase_t;

  // Command broadcast to one slot.
  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic             alloc;  // this slot takes the pressed key
  } slot_ctl_t;

  // Status of one slot.
  typedef struct packed {
    logic   used;
    logic   hit;   // slot holds the key of the current transaction
    phase_t phase;
  } slot_stat_t;

endpackage

// File: rtl/kst_slot.sv
module kst_slot (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd_en,
  input  kst_pkg::slot_ctl_t ctl,
  output kst_pkg::slot_stat_t stat,
  output kst_pkg::slot_stat_t stat_nxt
);
  import kst_pkg::*;

  logic             used_r, used_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  phase_t           phase_r, phase_nxt;
  logic             hit;

  assign hit = used_r && (key_r == ctl.key);

  always_comb begin
    used_nxt  = used_r;
    key_nxt   = key_r;
    phase_nxt = phase_r;
    case (ctl.cmd)
      CMD_TICK: begin
        if (used_r) begin
          case (phase_r)
            PH_RELEASED: begin
              used_nxt  = 1'b0;
              phase_nxt = PH_INVALID;
            end
            PH_REGISTERED:   phase_nxt = PH_TRIGGERED;
            PH_TRIGGERED:    phase_nxt = PH_PRESSED;
            PH_UNREGISTERED: phase_nxt = PH_RELEASED;
            default:         phase_nxt = phase_r;
          endcase
        end
      end
      CMD_PRESS: begin
        if (ctl.alloc) begin
          used_nxt  = 1'b1;
          key_nxt   = ctl.key;
          phase_nxt = PH_REGISTERED;
        end
      end
      CMD_RELEASE: begin
        if (hit) begin
          phase_nxt = PH_UNREGISTERED;
        end
      end
      CMD_CLEAR: begin
        used_nxt  = 1'b0;
        phase_nxt = PH_INVALID;
      end
      default: begin
        used_nxt = used_r;
      end
    endcase
  end

  assign stat.used      = used_r;
  assign stat.hit       = hit;
  assign stat.phase     = phase_r;
  assign stat_nxt.used  = used_nxt;
  assign stat_nxt.hit   = hit || ctl.alloc;
  assign stat_nxt.phase = phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (upd_en) begin
      used_r <= used_nxt;
    end
  end

  // Key and phase are only looked at while the slot is in use.
  always_ff @(posedge clk) begin
    if (upd_en) begin
      key_r   <= key_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: rtl/key_state_tracker.sv
// key_state_tracker keeps a table of TABLE_SLOTS held keys, each with a phase
// (registered, triggered, pressed, unregistered, released). Each input
// transaction carries a command in in_tuser (tick, press, release, query,
// clear) and a key code in in_tdata; each one produces exactly one output
// transaction with the phase of that key after the command (0 when absent)
// and a flag that is set when a press of a new key was dropped because every
// slot was in use. A new key takes the lowest free slot. The block accepts one
// transaction per clock cycle as long as results are taken. While a result
// waits on out_tready, the input register still takes one more transaction,
// and then in_tready drops until the result leaves. A command is captured in
// the input register on the edge that accepts it; once the output register is
// empty or being emptied, the whole table is compared, updated and read back
// into the output register, where the result is presented. Reset empties the
// table at once.
module key_state_tracker #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [24:0] key_code, [31:25] zero
  input  logic [2:0]  in_tuser,   // [2:0] command
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [2:0] key_state, [3] table_full, [7:4] zero
);
  import kst_pkg::*;

  // Input register stage.
  logic             s1_valid_r;
  cmd_t             s1_cmd_r;
  logic [KEY_W-1:0] s1_key_r;

  // Output register stage.
  logic               out_valid_r, out_valid_nxt;
  logic [PHASE_W-1:0] out_state_r, out_state_nxt;
  logic               out_full_r, out_full_nxt;

  logic advance;
  logic in_take;

  // A transaction in the input register moves on (and updates the table) when
  // the output register is empty or is being emptied in this cycle.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r <= cmd_t'(in_tuser);
      s1_key_r <= in_tdata[KEY_W-1:0];
    end
  end

  // Slot array.
  slot_ctl_t  slot_ctl  [TABLE_SLOTS];
  slot_stat_t slot_stat [TABLE_SLOTS];
  slot_stat_t slot_next [TABLE_SLOTS];

  logic [TABLE_SLOTS-1:0] free_vec;
  logic [TABLE_SLOTS-1:0] free_first;
  logic [TABLE_SLOTS-1:0] hit_vec;
  logic [TABLE_SLOTS-1:0] used_vec;
  logic                   hit_any;
  logic                   new_press;

  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      free_vec[i] = !slot_stat[i].used;
      hit_vec[i]  = slot_stat[i].hit;
      used_vec[i] = slot_stat[i].used;
    end
  end

  assign hit_any    = |hit_vec;
  // Lowest free slot as a one-hot vector.
  assign free_first = free_vec & (~free_vec + {{(TABLE_SLOTS-1){1'b0}}, 1'b1});
  assign new_press  = (s1_cmd_r == CMD_PRESS) && !hit_any;

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_slot
    assign slot_ctl[g].cmd   = s1_cmd_r;
    assign slot_ctl[g].key   = s1_key_r;
    assign slot_ctl[g].alloc = new_press && free_first[g];

    kst_slot u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .upd_en   (advance),
      .ctl      (slot_ctl[g]),
      .stat     (slot_stat[g]),
      .stat_nxt (slot_next[g])
    );
  end

  // The reported phase is read from the updated slot contents, so a tick that
  // frees a released key or a clear reports the key as absent.
  always_comb begin
    out_state_nxt = PHASE_W'(PH_INVALID);
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (slot_next[i].used && slot_next[i].hit) begin
        out_state_nxt = out_state_nxt | slot_next[i].phase;
      end
    end
    out_full_nxt = new_press && !(|free_vec);
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state_r <= out_state_nxt;
      out_full_r  <= out_full_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_full_r, out_state_r};

`ifndef ASSERT_OFF
  // A dropped press always reports the key as absent.
  a_full_invalid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> out_state_r == PHASE_W'(PH_INVALID))
    else $error("dropped press reported a valid phase");

  // A clear leaves every slot free.
  a_clear_empty : assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_cmd_r == CMD_CLEAR |=> used_vec == '0)
    else $error("slots still in use after clear");

  // A press that was not dropped leaves the key in the table.
  a_press_stored : assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_cmd_r == CMD_PRESS && !out_full_nxt
      |=> out_state_r != PHASE_W'(PH_INVALID))
    else $error("pressed key missing from table");
`endif

endmodule
